FILE: sv/touch_region_button_tracker_macros.svh
// Assertion macros shared by the touch region button tracker.
`ifndef TOUCH_REGION_BUTTON_TRACKER_MACROS_SVH
`define TOUCH_REGION_BUTTON_TRACKER_MACROS_SVH

// Checks that a condition implies another in the same cycle.
`define TRBT_ASSERT_NOW(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("assertion failed");

// Checks that a condition implies another in the next cycle.
`define TRBT_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("assertion failed");

`endif

FILE: sv/trbt_pkg.sv
// Types and constants of the touch region button tracker.
package trbt_pkg;

    localparam int FIELD_W     = 10;
    localparam int ID_W        = 8;
    localparam int MAX_REGIONS = 8;
    localparam int RIDX_W      = 3;
    localparam int CFG_DATA_W  = 60;
    localparam int CFG_IDX_W   = 3;
    localparam int PAIR_REGS   = 4;

    localparam logic [1:0] MODE_DOWN = 2'd0;
    localparam logic [1:0] MODE_MOVE = 2'd1;

    localparam logic [CFG_IDX_W-1:0] REG_ENABLE     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PAIR_FIRST = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PAIR_LAST  = 3'd4;

    typedef struct packed {
        logic [1:0]         mode;
        logic [FIELD_W-1:0] touch_x;
        logic [FIELD_W-1:0] touch_y;
        logic [ID_W-1:0]    finger_id;
    } trbt_in_t;

    typedef struct packed {
        logic [3:0]             hit_button;
        logic [MAX_REGIONS-1:0] pressed_mask;
    } trbt_out_t;

    typedef struct packed {
        logic              accept;
        logic              skip;
        logic              square;
        logic              compare;
        logic              update;
        logic [RIDX_W-1:0] region;
    } trbt_cmd_t;

    typedef struct packed {
        logic enable;
        logic in_region;
    } trbt_sts_t;

endpackage

FILE: sv/touch_region_button_tracker.sv
// Top level of the touch region button tracker.
//
// Channel   Ports                           Transfer
// input     start, busy, item               start high while busy low
// result    done, result                    done high, one cycle, no back pressure
// config    wr_en, wr_index, wr_data        wr_en high
//
// An enabled item runs a square and a compare state for each region tested,
// up to the first hit or last region; the update state then registers the result.
// A disabled item gives its result in the cycle after the transfer.
// Reset clears all finger counts, sets enable and clears the region registers.
// The receiver cannot stall; busy holds off new items while one is at work.
module touch_region_button_tracker #(
    parameter int REGIONS          = 8,
    parameter int SLOTS_PER_REGION = 10,
    parameter int COORD_BITS       = 10
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  trbt_pkg::trbt_in_t              item,
    output logic                            done,
    output trbt_pkg::trbt_out_t             result,
    input  logic                            wr_en,
    input  logic [trbt_pkg::CFG_IDX_W-1:0]  wr_index,
    input  logic [trbt_pkg::CFG_DATA_W-1:0] wr_data
);
    import trbt_pkg::*;
    `include "touch_region_button_tracker_macros.svh"

    trbt_cmd_t cmd;
    trbt_sts_t sts;

    trbt_ctrl #(
        .REGIONS(REGIONS)
    ) u_ctrl (
        .clk  (clk),
        .rst_n(rst_n),
        .start(start),
        .busy (busy),
        .done (done),
        .cmd  (cmd),
        .sts  (sts)
    );

    trbt_datapath #(
        .REGIONS         (REGIONS),
        .SLOTS_PER_REGION(SLOTS_PER_REGION),
        .COORD_BITS      (COORD_BITS)
    ) u_datapath (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (wr_en),
        .wr_index(wr_index),
        .wr_data (wr_data),
        .item    (item),
        .cmd     (cmd),
        .sts     (sts),
        .result  (result)
    );

    `TRBT_ASSERT_NEXT(a_accept_progress, clk, rst_n, start && !busy, busy || done)
    `TRBT_ASSERT_NOW(a_done_idle, clk, rst_n, done, !busy)
    `TRBT_ASSERT_NOW(a_hit_range, clk, rst_n, done, result.hit_button <= 4'(REGIONS))
    `TRBT_ASSERT_NOW(a_mask_range, clk, rst_n, done,
        (result.pressed_mask >> REGIONS) == '0)

endmodule

FILE: sv/trbt_ctrl.sv
// Controller state machine of the touch region button tracker.
module trbt_ctrl #(
    parameter int REGIONS = 8
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    output logic                done,
    output trbt_pkg::trbt_cmd_t cmd,
    input  trbt_pkg::trbt_sts_t sts
);
    import trbt_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SQ   = 2'd1;
    localparam logic [1:0] ST_CMP  = 2'd2;
    localparam logic [1:0] ST_UPD  = 2'd3;

    logic [1:0]        state_reg, state_next;
    logic [RIDX_W-1:0] idx_reg, idx_next;
    logic              done_reg, done_next;

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        done_next  = 1'b0;
        cmd        = '0;
        cmd.region = idx_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.accept = 1'b1;
                    idx_next   = '0;
                    if (sts.enable)
                    begin
                        state_next = ST_SQ;
                    end
                    else
                    begin
                        cmd.skip  = 1'b1;
                        done_next = 1'b1;
                    end
                end
            end
            ST_SQ:
            begin
                cmd.square = 1'b1;
                state_next = ST_CMP;
            end
            ST_CMP:
            begin
                cmd.compare = 1'b1;
                if (sts.in_region || idx_reg == RIDX_W'(REGIONS - 1))
                begin
                    state_next = ST_UPD;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = ST_SQ;
                end
            end
            ST_UPD:
            begin
                cmd.update = 1'b1;
                done_next  = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            done_reg  <= done_next;
        end
    end

    assign busy = (state_reg != ST_IDLE);
    assign done = done_reg;

endmodule

FILE: sv/trbt_datapath.sv
// Datapath of the touch region button tracker: registers, hit test and finger lists.
module trbt_datapath #(
    parameter int REGIONS          = 8,
    parameter int SLOTS_PER_REGION = 10,
    parameter int COORD_BITS       = 10
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                wr_en,
    input  logic [trbt_pkg::CFG_IDX_W-1:0]      wr_index,
    input  logic [trbt_pkg::CFG_DATA_W-1:0]     wr_data,
    input  trbt_pkg::trbt_in_t                  item,
    input  trbt_pkg::trbt_cmd_t                 cmd,
    output trbt_pkg::trbt_sts_t                 sts,
    output trbt_pkg::trbt_out_t                 result
);
    import trbt_pkg::*;

    localparam int CB    = COORD_BITS;
    localparam int SQ_W  = 2 * CB;
    localparam int CNT_W = $clog2(SLOTS_PER_REGION + 1);
    localparam int POS_W = (SLOTS_PER_REGION > 1) ? $clog2(SLOTS_PER_REGION) : 1;

    logic                  enable_reg;
    logic [CFG_DATA_W-1:0] pair_reg [PAIR_REGS];

    logic [1:0]      mode_reg;
    logic [CB-1:0]   x_reg, y_reg;
    logic [ID_W-1:0] id_reg;

    logic [SQ_W-1:0]   sqx_reg, sqy_reg, sqr_reg;
    logic              hit_valid_reg;
    logic [RIDX_W-1:0] hit_reg;

    logic [ID_W-1:0]  slot_reg [REGIONS][SLOTS_PER_REGION];
    logic [ID_W-1:0]  slot_next [REGIONS][SLOTS_PER_REGION];
    logic [CNT_W-1:0] cnt_reg [REGIONS];
    logic [CNT_W-1:0] cnt_next [REGIONS];

    trbt_out_t result_reg;

    logic [CFG_DATA_W-1:0] pair_sel;
    logic [3*CB-1:0]       half_sel;
    logic [CB-1:0]         cx, cy, cr, dx, dy;

    logic [REGIONS-1:0] found;
    logic [POS_W-1:0]   pos [REGIONS];
    logic               prev_valid;
    logic [RIDX_W-1:0]  prev;
    logic               is_down, adds;
    logic [MAX_REGIONS-1:0] mask_now, mask_next;

    always_comb
    begin
        pair_sel = pair_reg[cmd.region[RIDX_W-1:1]];
        half_sel = cmd.region[0] ? pair_sel[6*CB-1:3*CB] : pair_sel[3*CB-1:0];
        cx = half_sel[CB-1:0];
        cy = half_sel[2*CB-1:CB];
        cr = half_sel[3*CB-1:2*CB];
        dx = (x_reg > cx) ? (x_reg - cx) : (cx - x_reg);
        dy = (y_reg > cy) ? (y_reg - cy) : (cy - y_reg);
    end

    assign sts.enable    = enable_reg;
    assign sts.in_region = ({1'b0, sqx_reg} + {1'b0, sqy_reg}) <= {1'b0, sqr_reg};

    always_comb
    begin
        for (int i = 0; i < REGIONS; i++)
        begin
            found[i] = 1'b0;
            pos[i]   = '0;
            for (int j = 0; j < SLOTS_PER_REGION; j++)
            begin
                if (!found[i] && CNT_W'(j) < cnt_reg[i] && slot_reg[i][j] == id_reg)
                begin
                    found[i] = 1'b1;
                    pos[i]   = POS_W'(j);
                end
            end
        end
        prev_valid = 1'b0;
        prev       = '0;
        for (int i = 0; i < REGIONS; i++)
        begin
            if (found[i] && !prev_valid)
            begin
                prev_valid = 1'b1;
                prev       = RIDX_W'(i);
            end
        end
    end

    assign is_down = (mode_reg == MODE_DOWN);
    assign adds    = is_down || (mode_reg == MODE_MOVE);

    always_comb
    begin
        logic             rem, add_here, present;
        logic [CNT_W-1:0] cnt_a;
        for (int i = 0; i < REGIONS; i++)
        begin
            add_here = adds && hit_valid_reg && hit_reg == RIDX_W'(i);
            if (is_down)
            begin
                rem = found[i] && prev_valid && prev == RIDX_W'(i) && !add_here;
            end
            else
            begin
                rem = found[i];
            end
            cnt_a   = rem ? (cnt_reg[i] - 1'b1) : cnt_reg[i];
            present = found[i] && !rem;
            for (int j = 0; j < SLOTS_PER_REGION; j++)
            begin
                if (rem && POS_W'(j) >= pos[i] && j + 1 < SLOTS_PER_REGION)
                begin
                    slot_next[i][j] = slot_reg[i][(j + 1) % SLOTS_PER_REGION];
                end
                else
                begin
                    slot_next[i][j] = slot_reg[i][j];
                end
            end
            cnt_next[i] = cnt_a;
            if (add_here && !present && cnt_a < CNT_W'(SLOTS_PER_REGION))
            begin
                for (int j = 0; j < SLOTS_PER_REGION; j++)
                begin
                    if (CNT_W'(j) == cnt_a)
                    begin
                        slot_next[i][j] = id_reg;
                    end
                end
                cnt_next[i] = cnt_a + 1'b1;
            end
        end
    end

    always_comb
    begin
        mask_now  = '0;
        mask_next = '0;
        for (int i = 0; i < REGIONS; i++)
        begin
            mask_now[i]  = (cnt_reg[i] != '0);
            mask_next[i] = (cnt_next[i] != '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg    <= 1'b1;
            hit_valid_reg <= 1'b0;
            for (int k = 0; k < PAIR_REGS; k++)
            begin
                pair_reg[k] <= '0;
            end
            for (int i = 0; i < REGIONS; i++)
            begin
                cnt_reg[i] <= '0;
            end
        end
        else
        begin
            if (wr_en)
            begin
                if (wr_index == REG_ENABLE)
                begin
                    enable_reg <= wr_data[0];
                end
                else if (wr_index >= REG_PAIR_FIRST && wr_index <= REG_PAIR_LAST)
                begin
                    pair_reg[2'(wr_index - REG_PAIR_FIRST)] <= wr_data;
                end
            end
            if (cmd.accept)
            begin
                hit_valid_reg <= 1'b0;
            end
            else if (cmd.compare && sts.in_region)
            begin
                hit_valid_reg <= 1'b1;
            end
            if (cmd.update)
            begin
                for (int i = 0; i < REGIONS; i++)
                begin
                    cnt_reg[i] <= cnt_next[i];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            mode_reg <= item.mode;
            x_reg    <= item.touch_x[CB-1:0];
            y_reg    <= item.touch_y[CB-1:0];
            id_reg   <= item.finger_id;
        end
        if (cmd.square)
        begin
            sqx_reg <= dx * dx;
            sqy_reg <= dy * dy;
            sqr_reg <= cr * cr;
        end
        if (cmd.compare && sts.in_region)
        begin
            hit_reg <= cmd.region;
        end
        if (cmd.update)
        begin
            slot_reg                <= slot_next;
            result_reg.hit_button   <= hit_valid_reg ? ({1'b0, hit_reg} + 4'd1) : 4'd0;
            result_reg.pressed_mask <= mask_next;
        end
        else if (cmd.skip)
        begin
            result_reg.hit_button   <= 4'd0;
            result_reg.pressed_mask <= mask_now;
        end
    end

    assign result = result_reg;

endmodule

FILE: tb/tb_tracker_checker.sv
// Checker that predicts and compares the results of the touch region button tracker.
`timescale 1ns / 100ps
module tb_tracker_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic                            busy,
    input  trbt_pkg::trbt_in_t              item,
    input  logic                            done,
    input  trbt_pkg::trbt_out_t             result,
    input  logic                            wr_en,
    input  logic [trbt_pkg::CFG_IDX_W-1:0]  wr_index,
    input  logic [trbt_pkg::CFG_DATA_W-1:0] wr_data,
    output int                              fail_count,
    output int                              pending,
    output int                              result_count
);
    import trbt_pkg::*;

    localparam int SLOTS = 10;

    logic                  en_q;
    logic [CFG_DATA_W-1:0] pair_q [PAIR_REGS];
    logic [ID_W-1:0]       held [MAX_REGIONS][SLOTS];
    int                    held_cnt [MAX_REGIONS];
    trbt_out_t             expected_q [$];

    function automatic logic [FIELD_W-1:0] geom(int r, int sel);
        logic [CFG_DATA_W-1:0] w;
        w = pair_q[r / 2];
        return w[(r % 2) * 3 * FIELD_W + sel * FIELD_W +: FIELD_W];
    endfunction

    function automatic int find_finger(int r, logic [ID_W-1:0] id);
        for (int i = 0; i < held_cnt[r]; i++)
            if (held[r][i] == id)
                return i;
        return -1;
    endfunction

    function automatic void drop_finger(int r, logic [ID_W-1:0] id);
        int p;
        p = find_finger(r, id);
        if (p < 0)
            return;
        for (int j = p; j + 1 < held_cnt[r]; j++)
            held[r][j] = held[r][j + 1];
        held_cnt[r]--;
    endfunction

    function automatic void add_finger(int r, logic [ID_W-1:0] id);
        if (find_finger(r, id) >= 0 || held_cnt[r] >= SLOTS)
            return;
        held[r][held_cnt[r]] = id;
        held_cnt[r]++;
    endfunction

    function automatic logic [MAX_REGIONS-1:0] held_mask();
        logic [MAX_REGIONS-1:0] m;
        m = '0;
        for (int i = 0; i < MAX_REGIONS; i++)
            m[i] = held_cnt[i] > 0;
        return m;
    endfunction

    function automatic trbt_out_t track_touch(trbt_in_t t);
        trbt_out_t o;
        int hit, prev;
        longint dx, dy, rr;
        hit = -1;
        prev = -1;
        o.hit_button = 4'd0;
        if (en_q) begin
            for (int i = 0; i < MAX_REGIONS && hit < 0; i++) begin
                dx = longint'(t.touch_x) - longint'(geom(i, 0));
                dy = longint'(t.touch_y) - longint'(geom(i, 1));
                rr = longint'(geom(i, 2));
                if (dx * dx + dy * dy <= rr * rr)
                    hit = i;
            end
            for (int i = 0; i < MAX_REGIONS && prev < 0; i++)
                if (find_finger(i, t.finger_id) >= 0)
                    prev = i;
            if (t.mode == MODE_DOWN) begin
                if (prev >= 0 && prev != hit)
                    drop_finger(prev, t.finger_id);
                if (hit >= 0)
                    add_finger(hit, t.finger_id);
            end else begin
                for (int i = 0; i < MAX_REGIONS; i++)
                    drop_finger(i, t.finger_id);
                if (t.mode == MODE_MOVE && hit >= 0)
                    add_finger(hit, t.finger_id);
            end
            o.hit_button = 4'(hit + 1);
        end
        o.pressed_mask = held_mask();
        return o;
    endfunction

    always @(posedge clk or negedge rst_n) begin
        trbt_out_t e;
        if (!rst_n) begin
            en_q = 1'b1;
            for (int i = 0; i < PAIR_REGS; i++)
                pair_q[i] = '0;
            for (int i = 0; i < MAX_REGIONS; i++)
                held_cnt[i] = 0;
            expected_q.delete();
            fail_count = 0;
            result_count = 0;
        end else begin
            if (done) begin
                result_count++;
                if (expected_q.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("Unexpected result %h at %0t", result, $realtime);
                end else begin
                    e = expected_q.pop_front();
                    if (e.hit_button !== result.hit_button
                            || e.pressed_mask !== result.pressed_mask) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("Mismatch: expected button %0d mask %b, got %0d %b",
                                e.hit_button, e.pressed_mask,
                                result.hit_button, result.pressed_mask);
                    end
                end
            end
            if (start && !busy)
                expected_q.push_back(track_touch(item));
            if (wr_en) begin
                if (wr_index == REG_ENABLE)
                    en_q = wr_data[0];
                else if (wr_index >= REG_PAIR_FIRST && wr_index <= REG_PAIR_LAST)
                    pair_q[wr_index - REG_PAIR_FIRST] = wr_data;
            end
        end
        pending = expected_q.size();
    end
endmodule

FILE: tb/tb_top.sv
// Testbench top that drives touch events and settings into the tracker and gives the verdict.
`timescale 1ns / 100ps
module tb_top;
    import trbt_pkg::*;

    localparam logic [1:0] MODE_UP  = 2'd2;
    localparam logic [1:0] MODE_ODD = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd6;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  start = 1'b0;
    logic                  busy;
    trbt_in_t              item = '0;
    logic                  done;
    trbt_out_t             result;
    logic                  wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  wr_index = '0;
    logic [CFG_DATA_W-1:0] wr_data = '0;
    int                    fail_count, pending, result_count;
    int                    event_count = 0;
    logic [29:0]           layout [MAX_REGIONS];

    always #4 clk = ~clk;

    touch_region_button_tracker uut (.*);

    tb_tracker_checker chk (.*);

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(posedge clk);
        wr_en <= 1'b1;
        wr_index <= idx;
        wr_data <= val;
        @(posedge clk);
        wr_en <= 1'b0;
    endtask

    task automatic settle();
        start <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (24) @(posedge clk);
    endtask

    task automatic load_layout();
        for (int k = 0; k < PAIR_REGS; k++)
            write_reg(CFG_IDX_W'(REG_PAIR_FIRST + k), {layout[2 * k + 1], layout[2 * k]});
    endtask

    task automatic send_touch(logic [1:0] md, logic [9:0] x, logic [9:0] y, logic [7:0] id);
        int gap;
        gap = $urandom_range(0, 19);
        if (gap > 10)
            start <= 1'b0;
        if (gap > 16)
            repeat ($urandom_range(10, 40)) @(posedge clk);
        else if (gap > 10)
            repeat ($urandom_range(1, 3)) @(posedge clk);
        item <= '{mode: md, touch_x: x, touch_y: y, finger_id: id};
        start <= 1'b1;
        do
            @(posedge clk);
        while (busy);
        event_count++;
    endtask

    function automatic logic [9:0] near(logic [9:0] c, logic [9:0] r);
        int v;
        v = int'(c) + $signed($urandom_range(0, 2 * r + 8)) - int'(r) - 4;
        return (v < 0) ? 10'd0 : (v > 1023) ? 10'd1023 : 10'(v);
    endfunction

    initial begin
        #5000000;
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        int reg_pick;
        logic [1:0] md;
        logic [9:0] px, py;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        // Reset geometry: every region is a zero-radius point at the origin.
        send_touch(MODE_DOWN, 10'd0, 10'd0, 8'd1);
        send_touch(MODE_DOWN, 10'd1, 10'd0, 8'd2);
        send_touch(MODE_UP, 10'd0, 10'd0, 8'd1);
        settle();
        for (int i = 0; i < MAX_REGIONS; i++)
            layout[i] = {10'd60, 10'(100 + 110 * i), 10'(80 + 120 * i)};
        layout[7] = {10'd1023, 10'd1023, 10'd1023};
        load_layout();
        send_touch(MODE_DOWN, 10'd80, 10'd100, 8'd0);
        send_touch(MODE_DOWN, 10'd200, 10'd210, 8'd255);
        send_touch(MODE_DOWN, 10'd200, 10'd210, 8'd255);
        send_touch(MODE_MOVE, 10'd320, 10'd320, 8'd255);
        send_touch(MODE_DOWN, 10'd80, 10'd100, 8'd255);
        send_touch(MODE_ODD, 10'd80, 10'd100, 8'd0);
        send_touch(MODE_UP, 10'd1023, 10'd1023, 8'd255);
        send_touch(MODE_MOVE, 10'd0, 10'd1023, 8'd7);
        // Overfill one region with eleven fingers.
        for (int f = 0; f < 11; f++)
            send_touch(MODE_DOWN, 10'd440, 10'd430, 8'(f + 10));
        settle();
        write_reg(REG_ENABLE, 60'd0);
        send_touch(MODE_UP, 10'd440, 10'd430, 8'd10);
        send_touch(MODE_DOWN, 10'd80, 10'd100, 8'd3);
        settle();
        write_reg(REG_ENABLE, 60'd1);
        write_reg(REG_UNUSED, {60{1'b1}});
        for (int phase = 0; phase < 5; phase++) begin
            settle();
            for (int i = 0; i < MAX_REGIONS; i++) begin
                if (phase == 4)
                    layout[i] = {10'd1023, 20'($urandom)};
                else if (phase == 3)
                    layout[i] = {10'd0, 20'($urandom)};
                else
                    layout[i] = {10'($urandom_range(20, 200)), 10'($urandom),
                        10'($urandom)};
            end
            load_layout();
            if (phase == 2)
                write_reg(REG_PAIR_LAST, {60{1'b1}});
            for (int n = 0; n < 240; n++) begin
                reg_pick = $urandom_range(0, MAX_REGIONS - 1);
                md = ($urandom_range(0, 9) == 0) ? MODE_ODD : 2'($urandom_range(0, 2));
                if ($urandom_range(0, 9) < 8) begin
                    px = near(layout[reg_pick][9:0], layout[reg_pick][29:20]);
                    py = near(layout[reg_pick][19:10], layout[reg_pick][29:20]);
                end else begin
                    px = 10'($urandom);
                    py = 10'($urandom);
                end
                send_touch(md, px, py, ($urandom_range(0, 3) == 0) ? 8'($urandom)
                    : 8'($urandom_range(0, 15)));
                if (n == 120) begin
                    settle();
                    write_reg(REG_ENABLE, 60'($urandom_range(0, 1)));
                end
            end
            settle();
            write_reg(REG_ENABLE, 60'd1);
        end
        settle();
        $display("Covered %0d touch events and %0d results over seven region layouts,",
            event_count, result_count);
        $display("including disabled periods, full regions and the odd event kind.");
        if (fail_count == 0 && pending == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule

FILE: touch_region_button_tracker.f
+incdir+sv
sv/trbt_pkg.sv
sv/trbt_ctrl.sv
sv/trbt_datapath.sv
sv/touch_region_button_tracker.sv
tb/tb_tracker_checker.sv
tb/tb_top.sv
